### design/pgh_pkg.sv
// Shared types and constants for the pressure gate hysteresis block.
`default_nettype none

package pgh_pkg;

    // Gate states, encoded as on the result stream
    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_ARMED    = 2'd1,
        ST_ACTIVE   = 2'd2,
        ST_COOLDOWN = 2'd3
    } t_gate_state;

    // Gate mode register codes
    localparam logic [1:0] MODE_FORCE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_PRESSURE     = 2'd1;
    localparam logic [1:0] MODE_FORCE_ACTIVE = 2'd2;

    // Profile codes
    localparam logic [1:0] PROF_NORMAL = 2'd0;
    localparam logic [1:0] PROF_ARMED  = 2'd1;
    localparam logic [1:0] PROF_ACTIVE = 2'd2;

    // Register indexes (byte address is 8 * index)
    localparam logic [1:0] REG_GATE_MODE  = 2'd0;
    localparam logic [1:0] REG_ACT_WIN    = 2'd1;
    localparam logic [1:0] REG_REC_WIN    = 2'd2;
    localparam logic [1:0] REG_COOL_LEN   = 2'd3;

    localparam int COOL_W = 51;

    // Register reset values
    localparam logic [1:0]        RST_GATE_MODE = MODE_FORCE_NORMAL;
    localparam logic [7:0]        RST_ACT_WIN   = 8'd2;
    localparam logic [7:0]        RST_REC_WIN   = 8'd3;
    localparam logic [COOL_W-1:0] RST_COOL_LEN  = COOL_W'(64'd2000000000);

    // Evidence mask bit positions
    localparam int EV_CPU  = 0;
    localparam int EV_WAIT = 1;
    localparam int EV_BG   = 2;

    typedef struct packed {
        logic [1:0]        gate_mode;
        logic [7:0]        act_win;
        logic [7:0]        rec_win;
        logic [COOL_W-1:0] cool_len;
    } t_cfg;

    typedef struct packed {
        logic        background_present;
        logic        latency_present;
        logic        background_busy;
        logic        wait_high;
        logic        pressure_trigger;
        logic        cpu_high;
        logic [63:0] now_time;
    } t_item;

    typedef struct packed {
        logic [1:0]  profile_code;
        logic [31:0] generation_count;
        logic [2:0]  evidence_bits;
        logic [1:0]  new_state;
        logic [1:0]  prior_state;
    } t_result;

    // Gate context carried from window to window
    typedef struct packed {
        t_gate_state state;
        logic [7:0]  act_streak;
        logic [7:0]  rec_streak;
        logic [63:0] cool_start;
        logic [31:0] generation;
    } t_gate_ctx;

endpackage

`default_nettype wire

### design/pgh_cfg_regs.sv
// APB register file holding the gate configuration.
`default_nettype none

module pgh_cfg_regs
    import pgh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:3];
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_mode <= RST_GATE_MODE;
            r_cfg.act_win   <= RST_ACT_WIN;
            r_cfg.rec_win   <= RST_REC_WIN;
            r_cfg.cool_len  <= RST_COOL_LEN;
        end else if (w_wr) begin
            case (w_idx)
                REG_GATE_MODE: r_cfg.gate_mode <= pwdata[1:0];
                REG_ACT_WIN:   r_cfg.act_win   <= pwdata[7:0];
                REG_REC_WIN:   r_cfg.rec_win   <= pwdata[7:0];
                REG_COOL_LEN:  r_cfg.cool_len  <= pwdata[COOL_W-1:0];
                default:       r_cfg.gate_mode <= r_cfg.gate_mode;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (w_idx)
            REG_GATE_MODE: prdata = {62'd0, r_cfg.gate_mode};
            REG_ACT_WIN:   prdata = {56'd0, r_cfg.act_win};
            REG_REC_WIN:   prdata = {56'd0, r_cfg.rec_win};
            REG_COOL_LEN:  prdata = {{(64-COOL_W){1'b0}}, r_cfg.cool_len};
            default:       prdata = 64'd0;
        endcase
    end

endmodule

`default_nettype wire

### design/pgh_step.sv
// One window of the gate: evidence mask, next state and updated context.
`default_nettype none

module pgh_step
    import pgh_pkg::*;
(
    input  wire t_cfg      i_cfg,
    input  wire t_item     i_item,
    input  wire t_gate_ctx i_ctx,
    output t_gate_ctx      o_ctx,
    output t_result        o_result
);

    logic [2:0]  w_ev;
    logic        w_ev_two;
    logic [7:0]  w_act_inc;
    logic [7:0]  w_rec_inc;
    logic [7:0]  w_act_need;
    logic [7:0]  w_rec_need;
    logic        w_act_done;
    logic        w_rec_done;
    logic        w_recovering;
    logic        w_arm_drop;
    logic        w_cool_over;
    logic [63:0] w_elapsed;
    logic        w_pressure;
    t_gate_state n_state;

    // Evidence mask and "two or more set" test
    assign w_ev[EV_CPU]  = i_item.cpu_high |
                           ((i_cfg.gate_mode == MODE_PRESSURE) & i_item.pressure_trigger);
    assign w_ev[EV_WAIT] = i_item.wait_high;
    assign w_ev[EV_BG]   = i_item.background_busy;
    assign w_ev_two      = (w_ev[0] & w_ev[1]) | (w_ev[0] & w_ev[2]) | (w_ev[1] & w_ev[2]);

    assign w_pressure = (i_cfg.gate_mode == MODE_PRESSURE);

    // Saturating streak increments; a window count of zero acts as one
    assign w_act_inc  = (i_ctx.act_streak == 8'hFF) ? 8'hFF : i_ctx.act_streak + 8'd1;
    assign w_rec_inc  = (i_ctx.rec_streak == 8'hFF) ? 8'hFF : i_ctx.rec_streak + 8'd1;
    assign w_act_need = (i_cfg.act_win == 8'd0) ? 8'd1 : i_cfg.act_win;
    assign w_rec_need = (i_cfg.rec_win == 8'd0) ? 8'd1 : i_cfg.rec_win;
    assign w_act_done = w_act_inc >= w_act_need;
    assign w_rec_done = w_rec_inc >= w_rec_need;

    assign w_recovering = (!i_item.background_present && !w_ev[EV_CPU]) ||
                          (!i_item.background_present && !i_item.background_busy) ||
                          (!w_ev[EV_CPU] && !i_item.wait_high);
    assign w_arm_drop   = !i_item.latency_present ||
                          (!i_item.background_present && !w_ev_two);

    // Wrapping elapsed time since cooldown began
    assign w_elapsed   = i_item.now_time - i_ctx.cool_start;
    assign w_cool_over = w_elapsed >= {{(64-COOL_W){1'b0}}, i_cfg.cool_len};

    // Next state
    always_comb begin
        n_state = i_ctx.state;
        case (i_cfg.gate_mode)
            MODE_FORCE_NORMAL: n_state = ST_NORMAL;
            MODE_FORCE_ACTIVE: n_state = ST_ACTIVE;
            MODE_PRESSURE: begin
                case (i_ctx.state)
                    ST_NORMAL: begin
                        if (i_item.latency_present && i_item.background_present) begin
                            n_state = ST_ARMED;
                        end
                    end
                    ST_ARMED: begin
                        if (w_arm_drop) begin
                            n_state = ST_NORMAL;
                        end else if (w_ev_two && w_act_done) begin
                            n_state = ST_ACTIVE;
                        end
                    end
                    ST_ACTIVE: begin
                        if (w_recovering && w_rec_done) begin
                            n_state = ST_COOLDOWN;
                        end
                    end
                    ST_COOLDOWN: begin
                        if (i_item.background_present && w_ev_two) begin
                            n_state = ST_ACTIVE;
                        end else if (w_cool_over) begin
                            n_state = ST_NORMAL;
                        end
                    end
                    default: n_state = ST_NORMAL;
                endcase
            end
            default: n_state = i_ctx.state;
        endcase
    end

    // Context updates and result fields
    always_comb begin
        o_ctx            = i_ctx;
        o_ctx.state      = n_state;
        o_ctx.generation = i_ctx.generation + 32'd1;

        if (w_pressure) begin
            case (i_ctx.state)
                ST_ARMED: begin
                    if (w_arm_drop || !w_ev_two || w_act_done) begin
                        o_ctx.act_streak = 8'd0;
                    end else begin
                        o_ctx.act_streak = w_act_inc;
                    end
                end
                ST_ACTIVE: begin
                    if (!w_recovering || w_rec_done) begin
                        o_ctx.rec_streak = 8'd0;
                    end else begin
                        o_ctx.rec_streak = w_rec_inc;
                    end
                    if (w_recovering && w_rec_done) begin
                        o_ctx.cool_start = i_item.now_time;
                    end
                end
                default: o_ctx.act_streak = i_ctx.act_streak;
            endcase
        end

        o_result.prior_state      = i_ctx.state;
        o_result.new_state        = n_state;
        o_result.evidence_bits    = w_ev;
        o_result.generation_count = o_ctx.generation;
        case (n_state) inside
            ST_ACTIVE, ST_COOLDOWN: o_result.profile_code = PROF_ACTIVE;
            ST_ARMED:               o_result.profile_code = PROF_ARMED;
            default:                o_result.profile_code = PROF_NORMAL;
        endcase
    end

endmodule

`default_nettype wire

### design/pressure_gate_hysteresis_fsm_core.sv
// Top level: stream pipeline around the gate step logic and the APB registers.
//
//  channel   | role            | beat contents
//  ----------+-----------------+----------------------------------------------
//  s_axis    | window in       | now_time, cpu_high .. background_present
//  m_axis    | decision out    | prior/new state, evidence, generation, profile
//  APB       | configuration   | gate_mode, windows, cooldown_length
//
//  One window per cycle sustained when the output is not stalled. A beat is
//  captured in the input register, the decision is computed as it moves to the
//  output register, and the gate context registers update on that same edge.
//  Synchronous active-low reset clears the context and both valid flags.
//  A stalled output holds; the input register still takes one more beat.
`default_nettype none

module pressure_gate_hysteresis_fsm_core
    import pgh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: now_time[63:0], cpu_high[64], pressure_trigger[65], wait_high[66],
    //        background_busy[67], latency_present[68], background_present[69], zero pad
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: prior_state[1:0], new_state[3:2], evidence_bits[6:4],
    //        generation_count[38:7], profile_code[40:39], zero pad
    output logic      [47:0] m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    t_cfg      w_cfg;
    t_item     r_in;
    logic      r_in_valid;
    t_result   r_out;
    logic      r_out_valid;
    t_gate_ctx r_ctx;
    t_gate_ctx n_ctx;
    t_result   n_out;
    logic      w_adv;

    pgh_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pgh_step u_step (
        .i_cfg    (w_cfg),
        .i_item   (r_in),
        .i_ctx    (r_ctx),
        .o_ctx    (n_ctx),
        .o_result (n_out)
    );

    // Pipeline flow control
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out};

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= s_axis_tdata[69:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // Gate context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.state      <= ST_NORMAL;
            r_ctx.act_streak <= 8'd0;
            r_ctx.rec_streak <= 8'd0;
            r_ctx.cool_start <= 64'd0;
            r_ctx.generation <= 32'd0;
        end else if (w_adv) begin
            r_ctx <= n_ctx;
        end
    end

endmodule

`default_nettype wire
